[rtl/mmcc_pkg.sv]
// Package for the magic multiplier collision check.
// Holds table sizing, shift, epoch, queue and result FIFO constants, the queue
// entry and status types and the back-end state type. No dependencies.
package mmcc_pkg;

  // Mark table (power of two; the index is the low bits of the shifted product)
  localparam int TABLE_ENTRIES = 4096;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // Bitboard and multiplier split
  localparam int DATA_W = 64;
  localparam int HALF_W = DATA_W / 2;

  // Shift register
  localparam int                SHIFT_W     = 6;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd52;

  // Epoch tags: tag 0 means cleared, live epochs run 1..EPOCH_MAX
  localparam int                 EPOCH_W     = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;

  // Queue between front and back
  localparam int Q_DEPTH  = 8;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  // Result FIFO in the back end
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Classified item handed from front to back
  typedef struct packed {
    logic             first;
    logic             last;
    logic             attack_nz;
    logic [IDX_W-1:0] idx;
  } q_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_RUN,
    BK_WAIT
  } back_state_t;

endpackage

[rtl/mmcc_if.sv]
// Channel interfaces for the magic multiplier collision check.
// Item channel (input) and result channel (output), valid/ready handshake.
// Depends on mmcc_pkg.
interface mmcc_item_if import mmcc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              first;
  logic [DATA_W-1:0] candidate;
  logic [DATA_W-1:0] blocker_set;
  logic [DATA_W-1:0] attack_set;
  logic              last;

  modport source (output valid, first, candidate, blocker_set, attack_set, last,
                  input ready);
  modport sink   (input valid, first, candidate, blocker_set, attack_set, last,
                  output ready);
endinterface

interface mmcc_result_if;
  logic valid;
  logic ready;
  logic magic_ok;

  modport source (output valid, magic_ok, input ready);
  modport sink   (input valid, magic_ok, output ready);
endinterface

[rtl/mmcc_front.sv]
// Front end: accepts items, keeps the trial multiplier, computes the table index.
// Three stages: partial products, product sum, shift. Pushes into mmcc_queue.
// Depends on mmcc_pkg and mmcc_if.
module mmcc_front import mmcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  mmcc_item_if.sink          items,
  input  logic [SHIFT_W-1:0] index_shift,
  input  q_status_t          q_st,
  output logic               push,
  output q_entry_t           push_entry
);

  logic              accept;
  logic [DATA_W-1:0] held_candidate;
  logic [DATA_W-1:0] mult;
  logic [Q_CNT_W:0]  in_flight;

  // stage 1: partial products
  logic                s1_v;
  logic                s1_first, s1_last, s1_anz;
  logic [DATA_W-1:0]   s1_ll;
  logic [HALF_W-1:0]   s1_lh, s1_hl;

  // stage 2: full low product
  logic                s2_v;
  logic                s2_first, s2_last, s2_anz;
  logic [DATA_W-1:0]   s2_prod;
  logic [HALF_W-1:0]   cross_sum;

  // stage 3: index
  logic                s3_v;
  logic                s3_first, s3_last, s3_anz;
  logic [IDX_W-1:0]    s3_idx;
  logic [DATA_W-1:0]   shifted;

  // credit: queue entries plus items still in the front stages
  assign in_flight = {1'b0, q_st.count} + (Q_CNT_W+1)'(s1_v) + (Q_CNT_W+1)'(s2_v)
                   + (Q_CNT_W+1)'(s3_v);
  assign items.ready = in_flight < (Q_CNT_W+1)'(Q_DEPTH);
  assign accept      = items.valid & items.ready;

  // multiplier of this item: a first item brings its own
  assign mult = items.first ? items.candidate : held_candidate;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_candidate <= '0;
    end else if (accept && items.first) begin
      held_candidate <= items.candidate;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  assign cross_sum = s1_lh + s1_hl;
  assign shifted   = s2_prod >> index_shift;

  // datapath
  always_ff @(posedge clk) begin
    s1_first <= items.first;
    s1_last  <= items.last;
    s1_anz   <= |items.attack_set;
    s1_ll    <= {{HALF_W{1'b0}}, items.blocker_set[HALF_W-1:0]}
              * {{HALF_W{1'b0}}, mult[HALF_W-1:0]};
    s1_lh    <= items.blocker_set[HALF_W-1:0] * mult[DATA_W-1:HALF_W];
    s1_hl    <= items.blocker_set[DATA_W-1:HALF_W] * mult[HALF_W-1:0];

    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_anz   <= s1_anz;
    s2_prod  <= s1_ll + {cross_sum, {HALF_W{1'b0}}};

    s3_first <= s2_first;
    s3_last  <= s2_last;
    s3_anz   <= s2_anz;
    s3_idx   <= shifted[IDX_W-1:0];
  end

  assign push                 = s3_v;
  assign push_entry.first     = s3_first;
  assign push_entry.last      = s3_last;
  assign push_entry.attack_nz = s3_anz;
  assign push_entry.idx       = s3_idx;

endmodule

[rtl/mmcc_queue.sv]
// Short FIFO of classified items between front and back.
// Push is never issued when full (front holds credit).
// Depends on mmcc_pkg.
module mmcc_queue import mmcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  q_entry_t  push_entry,
  input  logic      pop,
  output q_entry_t  head,
  output q_status_t q_st
);

  q_entry_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  assign head       = entries[rd_ptr];
  assign q_st.count = count;
  assign q_st.empty = (count == '0);

endmodule

[rtl/mmcc_back.sv]
// Back end: mark table with epoch tags, collision check, trial flag, result FIFO.
// Table read at pop, check and mark in the cycle after, with write forwarding.
// Depends on mmcc_pkg and mmcc_if.
module mmcc_back import mmcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_entry_t  head,
  input  q_status_t q_st,
  output logic      pop,
  mmcc_result_if.source results
);

  back_state_t        state, state_next;
  logic [IDX_W-1:0]   sweep_cnt;
  logic [EPOCH_W-1:0] epoch_cnt;

  // tag table
  logic [EPOCH_W-1:0] tag_mem [TABLE_ENTRIES];
  logic [EPOCH_W-1:0] rd_tag;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;

  // check stage
  logic               w_v;
  q_entry_t           w_entry;
  logic [EPOCH_W-1:0] w_epoch;
  logic               trial_failed;
  logic               failed_in, marked, failed_new, mark_wr;

  // forward of the write made while this item's read was in flight
  logic               fwd_v;
  logic [IDX_W-1:0]   fwd_idx;
  logic [EPOCH_W-1:0] fwd_epoch;

  // result FIFO
  logic                 out_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr, out_rd;
  logic [OUT_CNT_W-1:0] out_cnt;
  logic                 out_push, out_pop;
  logic                 credit_ok;

  assign credit_ok = ({1'b0, out_cnt} + (OUT_CNT_W+1)'(w_v)) < (OUT_CNT_W+1)'(OUT_DEPTH);

  // next state and pop
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_SWEEP: begin
        if (sweep_cnt == IDX_W'(TABLE_ENTRIES - 1)) state_next = BK_RUN;
      end
      BK_RUN: begin
        if (!q_st.empty && credit_ok) begin
          if (head.first && epoch_cnt == EPOCH_MAX) state_next = BK_WAIT;
          else pop = 1'b1;
        end
      end
      BK_WAIT: begin
        if (!w_v) state_next = BK_SWEEP;
      end
      default: state_next = BK_SWEEP;
    endcase
  end

  // state, sweep counter, epoch counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_SWEEP;
      sweep_cnt <= '0;
      epoch_cnt <= EPOCH_FIRST;
    end else begin
      state <= state_next;
      if (state == BK_SWEEP) begin
        sweep_cnt <= sweep_cnt + 1'b1;
        if (state_next == BK_RUN) epoch_cnt <= EPOCH_FIRST;
      end else if (state == BK_WAIT) begin
        sweep_cnt <= '0;
      end
      if (pop && head.first) epoch_cnt <= epoch_cnt + 1'b1;
    end
  end

  // collision check
  always_comb begin
    failed_in  = w_entry.first ? 1'b0 : trial_failed;
    marked     = (rd_tag == w_epoch) ||
                 (fwd_v && fwd_idx == w_entry.idx && fwd_epoch == w_epoch);
    failed_new = failed_in | marked;
    mark_wr    = w_v && !failed_in && !marked && w_entry.attack_nz;
  end

  // table write port: sweep or mark
  always_comb begin
    if (state == BK_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt;
      mem_wdata = EPOCH_CLEAR;
    end else begin
      mem_we    = mark_wr;
      mem_waddr = w_entry.idx;
      mem_wdata = w_epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_waddr] <= mem_wdata;
    rd_tag <= tag_mem[head.idx];
  end

  // check stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      w_v          <= 1'b0;
      fwd_v        <= 1'b0;
      trial_failed <= 1'b0;
    end else begin
      w_v   <= pop;
      fwd_v <= mark_wr;
      if (w_v) trial_failed <= failed_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_entry <= head;
      w_epoch <= head.first ? epoch_cnt + 1'b1 : epoch_cnt;
    end
    fwd_idx   <= w_entry.idx;
    fwd_epoch <= w_epoch;
  end

  // result FIFO
  assign out_push = w_v && w_entry.last;
  assign out_pop  = results.valid && results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr  <= '0;
      out_rd  <= '0;
      out_cnt <= '0;
    end else begin
      if (out_push) out_wr <= out_wr + 1'b1;
      if (out_pop)  out_rd <= out_rd + 1'b1;
      unique case ({out_push, out_pop})
        2'b10:   out_cnt <= out_cnt + 1'b1;
        2'b01:   out_cnt <= out_cnt - 1'b1;
        default: out_cnt <= out_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_push) out_mem[out_wr] <= ~failed_new;
  end

  assign results.valid    = (out_cnt != '0);
  assign results.magic_ok = out_mem[out_rd];

endmodule

[rtl/magic_multiplier_collision_check.sv]
// Magic multiplier collision check, top level.
// Ties the shift register, front end, queue and back end together.
// Depends on mmcc_pkg, mmcc_if, mmcc_front, mmcc_queue, mmcc_back.
//
// Usage:
//   items   : one blocker combination per transaction (first, candidate,
//             blocker_set, attack_set, last); first starts a trial and loads
//             the candidate, last closes it.
//   results : one transaction per item with last set; magic_ok is 1 when no
//             two combinations of the trial met at the same table index.
//   cfg_we/cfg_wdata : index_shift write (reset 52), idle only, unchecked.
// Throughput: one item per cycle unless stalled. The product is built from
//   32x32 partial products over three front stages; the back end reads the
//   tag table once per item and marks it the following cycle.
// Result path: front stages, queue, check stage, result FIFO.
// Marks carry an epoch tag, so a new trial needs no clear. After reset, and
//   once every 254 trials when the epoch wraps, the back end sweeps the
//   4096-entry table; items are still taken into the queue until it fills,
//   then ready drops.
// When results stalls, the result FIFO fills, the back end stops popping,
//   the queue fills and items.ready goes low; nothing is dropped.
module magic_multiplier_collision_check import mmcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  mmcc_item_if.sink          items,
  mmcc_result_if.source      results,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_wdata
);

  logic [SHIFT_W-1:0] index_shift;
  logic               push, pop;
  q_entry_t           push_entry, head;
  q_status_t          q_st;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      index_shift <= SHIFT_RESET;
    end else if (cfg_we) begin
      index_shift <= cfg_wdata;
    end
  end

  mmcc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .index_shift (index_shift),
    .q_st        (q_st),
    .push        (push),
    .push_entry  (push_entry)
  );

  mmcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_st       (q_st)
  );

  mmcc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_st    (q_st),
    .pop     (pop),
    .results (results)
  );

endmodule
